/* hdl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
// Each use expands to one labelled concurrent assertion on the rising edge of clk,
// switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define AFCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define AFCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/afcc_pkg.sv */
// ----------------------------------------------------------------------------
// afcc_pkg
// Types, constants and functions of the addressed frame CRC checker.
// ----------------------------------------------------------------------------
package afcc_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
  localparam int LEN_W           = 7;
  localparam int MIN_FRAME_BYTES = 4;
  localparam int QDEPTH          = 2;
  localparam int QPTR_W          = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W          = $clog2(QDEPTH + 1);

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  ADDR_RST  = 8'h01;
  localparam logic [7:0]  ADDR_BCAST = 8'h00;

  localparam logic [7:0] CMD_20 = 8'h20;
  localparam logic [7:0] CMD_21 = 8'h21;
  localparam logic [7:0] CMD_22 = 8'h22;
  localparam logic [7:0] CMD_26 = 8'h26;
  localparam logic [7:0] CMD_27 = 8'h27;
  localparam logic [7:0] CMD_28 = 8'h28;
  localparam logic [7:0] CMD_29 = 8'h29;
  localparam logic [7:0] CMD_2A = 8'h2A;

  typedef enum logic [2:0] {
    V_ACCEPTED      = 3'd0,
    V_NOT_ADDRESSED = 3'd1,
    V_CRC_MISMATCH  = 3'd2,
    V_TOO_SHORT     = 3'd3,
    V_TOO_LONG      = 3'd4,
    V_UNKNOWN_CMD   = 3'd5
  } verdict_t;

  // Everything the back end needs to judge one finished frame.
  typedef struct packed {
    logic [7:0]       addr;
    logic [7:0]       cmd;
    logic [7:0]       pay_first;
    logic [7:0]       pay_second;
    logic [CNT_W-1:0] length;
    logic             overflow;
    logic [15:0]      crc_calc;
    logic [15:0]      crc_rx;
  } frame_rec_t;

  typedef struct packed {
    logic              empty;
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic known_command(input logic [7:0] c);
    return (c == CMD_20) || (c == CMD_21) || (c == CMD_22) || (c == CMD_26) ||
           (c == CMD_27) || (c == CMD_28) || (c == CMD_29) || (c == CMD_2A);
  endfunction

endpackage

/* hdl/afcc_if.sv */
// ----------------------------------------------------------------------------
// afcc channel interfaces
// Valid/ready channels for received bytes, frame verdicts and configuration.
// ----------------------------------------------------------------------------
interface afcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;
  modport source (output valid, rx_byte, end_of_frame, input ready);
  modport sink (input valid, rx_byte, end_of_frame, output ready);
endinterface

interface afcc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] verdict;
  logic       is_broadcast;
  logic [7:0] command_code;
  logic [7:0] payload_first;
  logic [7:0] payload_second;
  logic [6:0] frame_length;
  modport source (output valid, verdict, is_broadcast, command_code, payload_first,
                  payload_second, frame_length, input ready);
  modport sink (input valid, verdict, is_broadcast, command_code, payload_first,
                payload_second, frame_length, output ready);
endinterface

interface afcc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] station_address;
  modport source (output valid, station_address, input ready);
  modport sink (input valid, station_address, output ready);
endinterface

/* hdl/afcc_front.sv */
// ----------------------------------------------------------------------------
// afcc_front
// Accepts received bytes, keeps the running CRC and frame state, and hands a
// frame record to the queue on the last byte of each frame.
// ----------------------------------------------------------------------------
module afcc_front import afcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  afcc_in_if.sink     in_bus,
  input  q_stat_t     q_stat,
  output logic        push,
  output frame_rec_t  push_rec
);

  logic [15:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       held_r [4];
  logic [7:0]       held_nxt [4];
  logic [7:0]       trail0_r, trail0_nxt;
  logic [7:0]       trail1_r, trail1_nxt;
  logic             ovf_r, ovf_nxt;
  logic             accept;

  // Any byte may close a frame, so only take one while the queue has room.
  assign in_bus.ready = !q_stat.full;
  assign accept       = in_bus.valid && in_bus.ready;

  always_comb begin
    crc_nxt    = crc_r;
    cnt_nxt    = cnt_r;
    held_nxt   = held_r;
    trail0_nxt = trail0_r;
    trail1_nxt = trail1_r;
    ovf_nxt    = ovf_r;
    if (accept) begin
      // The CRC trails the input by two bytes, leaving out the received CRC.
      if (cnt_r >= CNT_W'(2)) begin
        crc_nxt = crc16_fold(crc_r, trail0_r);
      end
      trail0_nxt = trail1_r;
      trail1_nxt = in_bus.rx_byte;
      if (cnt_r < CNT_W'(MIN_FRAME_BYTES)) begin
        held_nxt[cnt_r[1:0]] = in_bus.rx_byte;
      end
      if (cnt_r >= CNT_W'(MAX_FRAME_BYTES)) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    push                = accept && in_bus.end_of_frame;
    push_rec.addr       = held_nxt[0];
    push_rec.cmd        = held_nxt[1];
    push_rec.pay_first  = held_nxt[2];
    push_rec.pay_second = held_nxt[3];
    push_rec.length     = cnt_nxt;
    push_rec.overflow   = ovf_nxt;
    push_rec.crc_calc   = crc_nxt;
    push_rec.crc_rx     = {trail1_nxt, trail0_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      crc_r    <= CRC_INIT;
      cnt_r    <= '0;
      held_r   <= '{default: 8'h00};
      trail0_r <= 8'h00;
      trail1_r <= 8'h00;
      ovf_r    <= 1'b0;
    end else begin
      crc_r    <= crc_nxt;
      cnt_r    <= cnt_nxt;
      held_r   <= held_nxt;
      trail0_r <= trail0_nxt;
      trail1_r <= trail1_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

endmodule

/* hdl/afcc_queue.sv */
// ----------------------------------------------------------------------------
// afcc_queue
// Short first-in first-out queue of frame records between front and back end.
// ----------------------------------------------------------------------------
module afcc_queue import afcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  frame_rec_t  push_rec,
  input  logic        pop,
  output frame_rec_t  pop_rec,
  output q_stat_t     q_stat
);

  frame_rec_t        store_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  assign pop_rec      = store_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.count = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

/* hdl/afcc_back.sv */
// ----------------------------------------------------------------------------
// afcc_back
// Judges queued frame records on length, station address, CRC and command, and
// drives the verdict channel from an output register.
// ----------------------------------------------------------------------------
module afcc_back import afcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  afcc_cfg_if.sink    cfg_bus,
  input  q_stat_t     q_stat,
  input  frame_rec_t  pop_rec,
  output logic        pop,
  afcc_out_if.source  out_bus
);

  logic [7:0]       station_r;
  logic             out_valid_r;
  verdict_t         verdict_r, verdict_nxt;
  logic             bcast_r;
  logic [7:0]       cmd_r, pay_first_r, pay_second_r;
  logic [LEN_W-1:0] len_r;

  assign cfg_bus.ready = 1'b1;

  // A new record moves in when the output register is empty or being drained.
  assign pop = !q_stat.empty && (!out_valid_r || out_bus.ready);

  always_comb begin
    priority if (pop_rec.length < CNT_W'(MIN_FRAME_BYTES)) begin
      verdict_nxt = V_TOO_SHORT;
    end else if (pop_rec.overflow) begin
      verdict_nxt = V_TOO_LONG;
    end else if (pop_rec.addr != station_r && pop_rec.addr != ADDR_BCAST) begin
      verdict_nxt = V_NOT_ADDRESSED;
    end else if (pop_rec.crc_rx != pop_rec.crc_calc) begin
      verdict_nxt = V_CRC_MISMATCH;
    end else if (!known_command(pop_rec.cmd)) begin
      verdict_nxt = V_UNKNOWN_CMD;
    end else begin
      verdict_nxt = V_ACCEPTED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r   <= ADDR_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        station_r <= cfg_bus.station_address;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict_r    <= verdict_nxt;
      bcast_r      <= (pop_rec.addr == ADDR_BCAST);
      cmd_r        <= pop_rec.cmd;
      pay_first_r  <= pop_rec.pay_first;
      pay_second_r <= pop_rec.pay_second;
      len_r        <= pop_rec.length[LEN_W-1:0];
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.verdict        = verdict_r;
  assign out_bus.is_broadcast   = bcast_r;
  assign out_bus.command_code   = cmd_r;
  assign out_bus.payload_first  = pay_first_r;
  assign out_bus.payload_second = pay_second_r;
  assign out_bus.frame_length   = len_r;

endmodule

/* hdl/addressed_frame_crc_checker.sv */
// Takes one received byte per cycle, back to back, while the frame queue has room.
// After the last byte of a frame is accepted, its record is written into the frame queue,
// then moves into the output register once that is free; there the verdict is valid.
// Synchronous active-low reset restores the station address to 1 and clears all frame state.
// ----------------------------------------------------------------------------
// addressed_frame_crc_checker
// Checks address, CRC-16/MODBUS, length and command of received frames and
// reports one verdict per frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module addressed_frame_crc_checker import afcc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  afcc_in_if.sink    in_bus,
  afcc_out_if.source out_bus,
  afcc_cfg_if.sink   cfg_bus
);

  q_stat_t    q_stat;
  logic       push;
  logic       pop;
  frame_rec_t push_rec;
  frame_rec_t pop_rec;

  afcc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  afcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .q_stat   (q_stat)
  );

  afcc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .q_stat  (q_stat),
    .pop_rec (pop_rec),
    .pop     (pop),
    .out_bus (out_bus)
  );

  // The queue never holds more records than it has room for.
  `AFCC_ASSERT_ALWAYS(a_q_bound, q_stat.count <= QCNT_W'(QDEPTH), "frame queue overrun")
  // A finished frame is held either in the queue or in the output register.
  `AFCC_ASSERT_NEXT(a_frame_kept, push, !q_stat.empty || out_bus.valid,
    "finished frame lost")
  // An accepted frame always carries at least the address, command and CRC.
  `AFCC_ASSERT_ALWAYS(a_accept_len,
    !(out_bus.valid && out_bus.verdict == V_ACCEPTED) ||
    out_bus.frame_length >= LEN_W'(MIN_FRAME_BYTES),
    "accepted verdict on a short frame")
  // Nothing is taken from an empty queue.
  `AFCC_ASSERT_ALWAYS(a_no_underrun, !(pop && q_stat.empty), "frame queue underrun")

endmodule
